/* src/sha512_pkg.sv */
// shared types, constants and round functions for the sha-512/384 hash unit
`default_nettype none
package sha512_pkg;

  localparam int NUM_ROUNDS = 80;
  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [0:0] MODE_SHA512 = 1'b0;
  localparam logic [0:0] MODE_SHA384 = 1'b1;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [6:0] LEN_POS = 7'd112;
  localparam logic [2:0] HASH_MODE_ADDR = 3'd0;

  typedef logic [63:0] word_t;

  function automatic word_t round_k(input logic [6:0] t);
    word_t k;
    case (t)
      7'd0: k = 64'h428a2f98d728ae22;  7'd1: k = 64'h7137449123ef65cd;
      7'd2: k = 64'hb5c0fbcfec4d3b2f;  7'd3: k = 64'he9b5dba58189dbbc;
      7'd4: k = 64'h3956c25bf348b538;  7'd5: k = 64'h59f111f1b605d019;
      7'd6: k = 64'h923f82a4af194f9b;  7'd7: k = 64'hab1c5ed5da6d8118;
      7'd8: k = 64'hd807aa98a3030242;  7'd9: k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic word_t init_value(input logic mode, input logic [2:0] i);
    word_t v;
    case ({mode, i})
      4'd0: v = 64'h6a09e667f3bcc908;  4'd1: v = 64'hbb67ae8584caa73b;
      4'd2: v = 64'h3c6ef372fe94f82b;  4'd3: v = 64'ha54ff53a5f1d36f1;
      4'd4: v = 64'h510e527fade682d1;  4'd5: v = 64'h9b05688c2b3e6c1f;
      4'd6: v = 64'h1f83d9abfb41bd6b;  4'd7: v = 64'h5be0cd19137e2179;
      4'd8: v = 64'hcbbb9d5dc1059ed8;  4'd9: v = 64'h629a292a367cd507;
      4'd10: v = 64'h9159015a3070dd17; 4'd11: v = 64'h152fecd8f70e5939;
      4'd12: v = 64'h67332667ffc00b31; 4'd13: v = 64'h8eb44a8768581511;
      4'd14: v = 64'hdb0c2e0d64f98fa7; 4'd15: v = 64'h47b5481dbefa4fa4;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } comp_ctl_t;

endpackage
`default_nettype wire

/* src/sha512_round.sv */
// shared round unit: one sha-512 round and schedule step per cycle
`default_nettype none
module sha512_round import sha512_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire word_t      init_a,
  input  wire word_t      init_b,
  input  wire word_t      init_c,
  input  wire word_t      init_d,
  input  wire word_t      init_e,
  input  wire word_t      init_f,
  input  wire word_t      init_g,
  input  wire word_t      init_h,
  input  wire word_t      msg_word,
  output logic [3:0]      msg_index,
  output comp_ctl_t       ctl,
  output word_t           va,
  output word_t           vb,
  output word_t           vc,
  output word_t           vd,
  output word_t           ve,
  output word_t           vf,
  output word_t           vg,
  output word_t           vh
);

  logic [6:0] round_number;
  logic       busy;
  logic       done;
  word_t      win [16];
  word_t      w, s0, s1, t1, t2, w15, w2;

  assign msg_index = round_number[3:0];

  always_comb begin
    w15 = win[4'(round_number - 7'd15)];
    w2  = win[4'(round_number - 7'd2)];
    s0  = rotr(w15, 1) ^ rotr(w15, 8) ^ (w15 >> 7);
    s1  = rotr(w2, 19) ^ rotr(w2, 61) ^ (w2 >> 6);
    if (round_number < 7'd16) begin
      w = msg_word;
    end else begin
      w = win[round_number[3:0]] + s0 + win[4'(round_number - 7'd7)] + s1;
    end
    t1 = vh + (rotr(ve, 14) ^ rotr(ve, 18) ^ rotr(ve, 41))
       + ((ve & vf) ^ (~ve & vg)) + round_k(round_number) + w;
    t2 = (rotr(va, 28) ^ rotr(va, 34) ^ rotr(va, 39))
       + ((va & vb) ^ (va & vc) ^ (vb & vc));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      round_number <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        round_number <= '0;
      end else if (busy) begin
        if (round_number == LAST_ROUND) begin
          busy <= 1'b0;
          done <= 1'b1;
          round_number <= '0;
        end else begin
          round_number <= round_number + 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      va <= init_a; vb <= init_b; vc <= init_c; vd <= init_d;
      ve <= init_e; vf <= init_f; vg <= init_g; vh <= init_h;
    end else if (busy) begin
      win[round_number[3:0]] <= w;
      vh <= vg; vg <= vf; vf <= ve; ve <= vd + t1;
      vd <= vc; vc <= vb; vb <= va; va <= t1 + t2;
    end
  end

  assign ctl = '{start: start, busy: busy, done: done};

endmodule
`default_nettype wire

/* src/sha512_sha384_hash_unit.sv */
// top level: byte intake, block buffer, padding, compression control and digest output
//
// channel  dir  fields
// s_axis   in   tdata = data_byte ; tuser = has_byte ; tlast = last_byte
// m_axis   out  tdata = digest_word ; tuser = word_index ; tlast = last_word
// apb      in   hash_mode at byte address 0
//
// a plain byte beat is taken at once; a beat that fills a block then holds s_axis_tready
// low through the rounds, the done strobe, the chain-word fold and the wait state
// an end beat pads byte by byte (with one or two compressions)
// and then holds eight or six digest beats, stalled by m_axis_tready
// reset loads the sha-512 initial values; s_axis_tready is low while busy
`default_nettype none
module sha512_sha384_hash_unit import sha512_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // data_byte
  input  wire logic        s_axis_tuser,   // has_byte
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // digest_word
  output logic [2:0]       m_axis_tuser,   // word_index
  output logic             m_axis_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_COMP  = 6'b000010,
    ST_WAIT  = 6'b000100,
    ST_PAD   = 6'b001000,
    ST_FOLD  = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t      state;
  logic        hash_mode;
  word_t       cv [8];
  word_t       buffer [16];
  logic [6:0]  block_fill;
  logic [63:0] byte_count;
  logic        padding;
  logic        len_block;
  logic        end_beat;
  logic [2:0]  out_idx;
  word_t       msg_word;
  logic [3:0]  msg_index;
  comp_ctl_t   ctl;
  word_t       va, vb, vc, vd, ve, vf, vg, vh;
  word_t       vsel;
  logic        cfg_wr;
  logic        in_acc;
  logic        put;
  logic [7:0]  put_byte;
  logic [7:0]  pad_byte;
  logic [63:0] bit_len;
  logic [2:0]  last_idx;
  logic        start;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == HASH_MODE_ADDR);
  assign prdata = {31'd0, hash_mode};
  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign bit_len = {byte_count[60:0], 3'b000};
  assign last_idx = (hash_mode == MODE_SHA384) ? 3'd5 : 3'd7;

  // length field only in the block that holds it
  always_comb begin
    pad_byte = 8'd0;
    if (len_block && block_fill == LEN_POS + 7'd7) pad_byte = {5'd0, byte_count[63:61]};
    else if (len_block && block_fill > LEN_POS + 7'd7)
      pad_byte = bit_len[8 * (7'd127 - block_fill) +: 8];
    if (!padding) pad_byte = PAD_BYTE;
  end

  always_comb begin
    put = 1'b0;
    put_byte = s_axis_tdata;
    if (state == ST_IDLE && in_acc && s_axis_tuser) put = 1'b1;
    if (state == ST_PAD) begin
      put = 1'b1;
      put_byte = pad_byte;
    end
  end

  assign start = put && (block_fill == 7'd127);

  // big-endian byte lanes; message word for the next round read ahead
  always_ff @(posedge clk) begin
    if (put) buffer[block_fill[6:3]][8 * (7 - block_fill[2:0]) +: 8] <= put_byte;
    if (start) msg_word <= buffer[4'd0];
    else msg_word <= buffer[msg_index + 4'd1];
  end

  sha512_round u_round (
    .clk(clk), .rst(rst), .start(start),
    .init_a(cv[0]), .init_b(cv[1]), .init_c(cv[2]), .init_d(cv[3]),
    .init_e(cv[4]), .init_f(cv[5]), .init_g(cv[6]), .init_h(cv[7]),
    .msg_word(msg_word), .msg_index(msg_index), .ctl(ctl),
    .va(va), .vb(vb), .vc(vc), .vd(vd), .ve(ve), .vf(vf), .vg(vg), .vh(vh)
  );

  always_comb begin
    case (out_idx)
      3'd0: vsel = va; 3'd1: vsel = vb; 3'd2: vsel = vc; 3'd3: vsel = vd;
      3'd4: vsel = ve; 3'd5: vsel = vf; 3'd6: vsel = vg;
      default: vsel = vh;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      if (rst) hash_mode <= MODE_SHA512;
      else hash_mode <= pwdata[0];
      for (int i = 0; i < 8; i++)
        cv[i] <= init_value(rst ? MODE_SHA512 : pwdata[0], 3'(i));
      block_fill <= '0;
      byte_count <= '0;
      padding <= 1'b0;
      len_block <= 1'b0;
      end_beat <= 1'b0;
      state <= ST_IDLE;
      out_idx <= '0;
    end else begin
      if (put) block_fill <= block_fill + 7'd1;
      case (state)
        ST_IDLE: begin
          end_beat <= in_acc && s_axis_tlast;
          if (in_acc) begin
            if (s_axis_tuser) byte_count <= byte_count + 64'd1;
            if (start) state <= ST_COMP;
            else if (s_axis_tlast) state <= ST_PAD;
          end
        end
        ST_PAD: begin
          padding <= 1'b1;
          if (!padding && block_fill < LEN_POS) len_block <= 1'b1;
          if (block_fill == 7'd127) state <= ST_COMP;
        end
        ST_COMP: begin
          if (ctl.done) begin
            state <= ST_FOLD;
            out_idx <= '0;
          end
        end
        ST_FOLD: begin
          cv[out_idx] <= cv[out_idx] + vsel;
          out_idx <= out_idx + 3'd1;
          if (out_idx == 3'd7) begin
            out_idx <= '0;
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (!end_beat) state <= ST_IDLE;
          else if (padding && len_block) state <= ST_OUT;
          else begin
            // length goes into the following block
            if (padding) len_block <= 1'b1;
            state <= ST_PAD;
          end
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == last_idx) begin
              out_idx <= '0;
              for (int i = 0; i < 8; i++) cv[i] <= init_value(hash_mode, 3'(i));
              byte_count <= '0;
              padding <= 1'b0;
              len_block <= 1'b0;
              end_beat <= 1'b0;
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata  = cv[out_idx];
  assign m_axis_tuser  = out_idx;
  assign m_axis_tlast  = (out_idx == last_idx);

`ifndef NO_ASSERTIONS
  a_out_only_when_idle_in: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("output while input open");
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_idx <= last_idx)) else $error("digest index out of range");
  a_done_in_comp: assert property (@(posedge clk) disable iff (rst)
    ctl.done |-> (state == ST_COMP)) else $error("round unit done outside compression");
`endif

endmodule
`default_nettype wire

/* tb/sha512_digest_checker.sv */
// digest checker: watches the byte, digest and register channels, predicts and compares
`default_nettype none
module sha512_digest_checker import sha512_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,
  input  wire logic        s_axis_tuser,
  input  wire logic        s_axis_tlast,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [63:0] m_axis_tdata,
  input  wire logic [2:0]  m_axis_tuser,
  input  wire logic        m_axis_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic [31:0] prdata,
  input  wire logic        pready,
  output int               mismatches,
  output int               outstanding,
  output int               words_checked
);

  localparam word_t ROUND_CONST [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  localparam word_t START_512 [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };
  localparam word_t START_384 [8] = '{
    64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
    64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
  };

  typedef struct {
    word_t      word;
    logic [2:0] index;
    logic       final_word;
  } digest_beat_t;

  digest_beat_t digest_fifo[$];
  logic         mode;
  word_t        chain[8];
  logic [7:0]   block_bytes[128];
  int           fill;
  logic [63:0]  byte_count;

  function automatic word_t rot(word_t x, int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic void restart();
    for (int i = 0; i < 8; i++) chain[i] = (mode == MODE_SHA384) ? START_384[i] : START_512[i];
    fill = 0;
    byte_count = '0;
  endfunction

  function automatic void compress();
    word_t w[16];
    word_t v[8];
    word_t wt, a15, a2, t1, t2;
    for (int j = 0; j < 8; j++) v[j] = chain[j];
    for (int t = 0; t < 80; t++) begin
      if (t < 16) begin
        wt = '0;
        for (int j = 0; j < 8; j++) wt = (wt << 8) | word_t'(block_bytes[t * 8 + j]);
      end else begin
        a15 = w[(t - 15) & 15];
        a2 = w[(t - 2) & 15];
        wt = w[t & 15] + (rot(a15, 1) ^ rot(a15, 8) ^ (a15 >> 7)) + w[(t - 7) & 15]
           + (rot(a2, 19) ^ rot(a2, 61) ^ (a2 >> 6));
      end
      w[t & 15] = wt;
      t1 = v[7] + (rot(v[4], 14) ^ rot(v[4], 18) ^ rot(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[t] + wt;
      t2 = (rot(v[0], 28) ^ rot(v[0], 34) ^ rot(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) chain[j] += v[j];
    fill = 0;
  endfunction

  function automatic void absorb(logic [7:0] b);
    block_bytes[fill] = b;
    fill++;
    if (fill == 128) compress();
  endfunction

  function automatic void finish_message();
    logic [127:0] bit_len;
    digest_beat_t d;
    int words;
    bit_len = {64'd0, byte_count} << 3;
    absorb(PAD_BYTE);
    while (fill != int'(LEN_POS)) absorb(8'h00);
    for (int i = 15; i >= 0; i--) absorb(bit_len[i * 8 +: 8]);
    words = (mode == MODE_SHA384) ? 6 : 8;
    for (int i = 0; i < words; i++) begin
      d.word = chain[i];
      d.index = 3'(i);
      d.final_word = (i == words - 1);
      digest_fifo.push_back(d);
    end
    restart();
  endfunction

  always @(posedge clk) begin
    digest_beat_t e;
    if (rst) begin
      mode = MODE_SHA512;
      restart();
      digest_fifo.delete();
      mismatches = 0;
      words_checked = 0;
    end else begin
      if (prdata !== {31'd0, mode}) begin
        mismatches++;
        if (mismatches <= 10)
          $display("register readback: expected %h got %h", {31'd0, mode}, prdata);
      end
      if (psel && penable && pwrite && pready && paddr == HASH_MODE_ADDR) begin
        mode = pwdata[0];
        restart();
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser) begin
          absorb(s_axis_tdata);
          byte_count++;
        end
        if (s_axis_tlast) finish_message();
      end
      if (m_axis_tvalid && m_axis_tready) begin
        words_checked++;
        if (digest_fifo.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected digest beat %h index %0d", m_axis_tdata, m_axis_tuser);
        end else begin
          e = digest_fifo.pop_front();
          if (m_axis_tdata !== e.word || m_axis_tuser !== e.index ||
              m_axis_tlast !== e.final_word) begin
            mismatches++;
            if (mismatches <= 10)
              $display("digest mismatch: expected %h/%0d/%0b got %h/%0d/%0b",
                       e.word, e.index, e.final_word,
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
          end
        end
      end
    end
    outstanding = digest_fifo.size();
  end

endmodule
`default_nettype wire

/* tb/testbench.sv */
// testbench top: clock, reset, byte stimulus, register writes, back-pressure and verdict
`default_nettype none
module testbench import sha512_pkg::*;;

  localparam logic [2:0] SPARE_ADDR = 3'd4;
  localparam int QUIET_PAUSE = 400;
  localparam int STALL_LIMIT = 5000;
  localparam int ITEM_TARGET = 410;
  localparam int CALM_FROM = 350;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;   // has_byte
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;          // digest_word
  logic [2:0]  m_axis_tuser;          // word_index
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int mismatches, outstanding, words_checked;
  int items = 0;
  int messages = 0;
  int mode_writes = 0;
  int stall_count = 0;
  int hold = 0;
  bit calm = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sha512_sha384_hash_unit dut (.*);

  sha512_digest_checker checker_i (.*);

  // random back-pressure on the digest side
  always @(posedge clk) begin
    logic ready_next;
    if (calm || rst) ready_next = 1'b1;
    else if (hold > 0) begin
      hold--;
      ready_next = 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      hold = $urandom_range(0, 9);
      ready_next = 1'b0;
    end else ready_next = 1'b1;
    m_axis_tready <= ready_next;
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      stall_count <= 0;
    else if (stall_count >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("tb: failure");
      $finish;
    end else stall_count <= stall_count + 1;
  end

  task automatic send_beat(logic [7:0] data, bit has, bit last);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= data;
    s_axis_tuser <= has;
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    if (has || last) items++;
  endtask

  task automatic end_stream();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_message(int len, bit bare_end);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
      send_beat(8'($urandom), 1'b1, (i == len - 1) && !bare_end);
    end
    if (bare_end || len == 0) send_beat(8'($urandom), 1'b0, 1'b1);
    messages++;
  endtask

  // drain all digests, then let any padding or compression finish
  task automatic settle();
    end_stream();
    while (outstanding != 0) @(posedge clk);
    repeat (QUIET_PAUSE) @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    if (addr == HASH_MODE_ADDR) mode_writes++;
  endtask

  initial begin
    int len;
    int r;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty message, idle beat, extreme bytes, bare end after bytes
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'hff, 1'b0, 1'b0);
    send_beat(8'h00, 1'b1, 1'b1);
    send_beat(8'hff, 1'b1, 1'b0);
    send_beat(8'h5a, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h63, 1'b1, 1'b1);
    settle();
    apb_write(SPARE_ADDR, 32'hffff_ffff);
    send_beat(8'ha5, 1'b1, 1'b1);
    settle();
    apb_write(HASH_MODE_ADDR, 32'h8000_0001);
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'h80, 1'b1, 1'b1);
    send_beat(8'h3c, 1'b1, 1'b0);
    send_beat(8'hc3, 1'b1, 1'b0);
    settle();
    // abandons the two bytes above
    apb_write(HASH_MODE_ADDR, 32'hffff_fffe);
    send_beat(8'h7e, 1'b1, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      settle();
      apb_write(HASH_MODE_ADDR, {31'($urandom), phase[0] ^ 1'b1});
      while (items < ITEM_TARGET * (phase + 1) / 4) begin
        if (items >= CALM_FROM) calm = 1;
        r = $urandom_range(0, 19);
        if (r < 12) len = $urandom_range(0, 16);
        else if (r < 16) len = $urandom_range(17, 111);
        else if (r < 19) len = $urandom_range(108, 132);
        else len = $urandom_range(200, 260);
        if (phase == 3 && len > ITEM_TARGET - items) len = ITEM_TARGET - items;
        if (!calm && $urandom_range(0, 11) == 0) begin
          for (int i = 0; i < len % 40 + 1; i++) send_beat(8'($urandom), 1'b1, 1'b0);
          settle();
          apb_write(HASH_MODE_ADDR, {31'($urandom), phase[0] ^ 1'b1});
        end else send_message(len, $urandom_range(0, 2) == 0);
      end
    end
    settle();

    $display("%0d items in %0d messages, %0d register writes, both hash modes",
             items, messages, mode_writes);
    $display("%0d digest words compared under random stalls on both sides", words_checked);
    if (mismatches == 0 && outstanding == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
`default_nettype wire
